### design/rlasp_pkg.sv
package rlasp_pkg;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned IdxWidth  = 3;

  typedef enum logic [IdxWidth-1:0] {
    REG_GAIN  = 3'd0,
    REG_SPEED = 3'd1,
    REG_VSTEP = 3'd2,
    REG_TICK  = 3'd3,
    REG_LOWER = 3'd4,
    REG_UPPER = 3'd5
  } reg_idx_e;

  localparam logic [15:0] GainReset  = 16'd2304;
  localparam logic [30:0] SpeedReset = 31'd823550;
  localparam logic [30:0] VstepReset = 31'd5833;
  localparam logic [15:0] TickReset  = 16'd66;
  localparam logic [31:0] LowerReset = 32'hFFFF_8000;
  localparam logic [31:0] UpperReset = 32'h0000_8000;

  typedef struct packed {
    logic [15:0]        aim_gain;
    logic [30:0]        speed_limit;
    logic [30:0]        velocity_step_limit;
    logic [15:0]        tick_period;
    logic signed [31:0] lower_angle_limit;
    logic signed [31:0] upper_angle_limit;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic goal_en;
    logic err_en;
    logic mulg_en;
    logic vcmd_en;
    logic vel_en;
    logic mult_en;
    logic upd_en;
  } cmd_t;

  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [31:0] v,
                                                 input logic signed [31:0] lo,
                                                 input logic signed [31:0] hi);
    logic signed [31:0] r;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

### design/rlasp_if.sv
interface rlasp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] measured_angle;
  logic signed [31:0] aim_error;
  logic signed [31:0] manual_delta;
  logic               aim_active;

  modport source (output valid, measured_angle, aim_error, manual_delta, aim_active,
                  input ready);
  modport sink   (input valid, measured_angle, aim_error, manual_delta, aim_active,
                  output ready);
endinterface

interface rlasp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle_setpoint;
  logic signed [31:0] planned_velocity;
  logic               goal_reached;

  modport source (output valid, angle_setpoint, planned_velocity, goal_reached,
                  input ready);
  modport sink   (input valid, angle_setpoint, planned_velocity, goal_reached,
                  output ready);
endinterface

### design/rate_limited_aim_setpoint_planner_top.sv
// Channel   Direction  Payload
// in_if     sink       measured_angle, aim_error, manual_delta, aim_active
// out_if    source     angle_setpoint, planned_velocity, goal_reached
// apb       slave      aim_gain, speed_limit, velocity_step_limit, tick_period,
//                      lower_angle_limit, upper_angle_limit
//
// A result is registered after its item is accepted and has passed the steps goal, error,
// gain multiply, velocity clamp, velocity step, tick multiply, setpoint update,
// with one shared multiplier stepped by the sequencer.
// A new item is taken only when the sequencer is idle again after the previous update.
// A result waiting in the output register stalls only the final update.
// Reset clears setpoint and velocity and loads the register reset values.
module rate_limited_aim_setpoint_planner_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  rlasp_in_if.sink                        in_if,
  rlasp_out_if.source                     out_if,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [rlasp_pkg::AddrWidth-1:0] paddr,
  input  logic [rlasp_pkg::DataWidth-1:0] pwdata,
  output logic [rlasp_pkg::DataWidth-1:0] prdata,
  output logic                            pready
);

  rlasp_pkg::cfg_t cfg;
  rlasp_pkg::cmd_t cmd;

  rlasp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rlasp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd)
  );

  rlasp_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .cfg_i              (cfg),
    .measured_angle_i   (in_if.measured_angle),
    .aim_error_i        (in_if.aim_error),
    .manual_delta_i     (in_if.manual_delta),
    .aim_active_i       (in_if.aim_active),
    .angle_setpoint_o   (out_if.angle_setpoint),
    .planned_velocity_o (out_if.planned_velocity),
    .goal_reached_o     (out_if.goal_reached)
  );

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.upd_en |-> (!out_if.valid || out_if.ready))
    else $error("pending item overwritten");

  a_reached_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.goal_reached) |-> (out_if.planned_velocity == 32'sd0))
    else $error("goal reached with nonzero velocity");

  a_sp_limits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.upd_en && (cfg.lower_angle_limit <= cfg.upper_angle_limit)) |=>
      ((out_if.angle_setpoint >= $past(cfg.lower_angle_limit))
       && (out_if.angle_setpoint <= $past(cfg.upper_angle_limit))))
    else $error("setpoint outside limits");
`endif

endmodule

### design/rlasp_regs.sv
module rlasp_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rlasp_pkg::AddrWidth-1:0] paddr,
  input  logic [rlasp_pkg::DataWidth-1:0] pwdata,
  output logic [rlasp_pkg::DataWidth-1:0] prdata,
  output logic                           pready,
  output rlasp_pkg::cfg_t                cfg_o
);

  rlasp_pkg::cfg_t                   cfg_q;
  logic [rlasp_pkg::IdxWidth-1:0]    idx;
  logic                              wr_en;

  assign idx    = paddr[rlasp_pkg::AddrWidth-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.aim_gain            <= rlasp_pkg::GainReset;
      cfg_q.speed_limit         <= rlasp_pkg::SpeedReset;
      cfg_q.velocity_step_limit <= rlasp_pkg::VstepReset;
      cfg_q.tick_period         <= rlasp_pkg::TickReset;
      cfg_q.lower_angle_limit   <= rlasp_pkg::LowerReset;
      cfg_q.upper_angle_limit   <= rlasp_pkg::UpperReset;
    end else if (wr_en) begin
      case (idx)
        rlasp_pkg::REG_GAIN:  cfg_q.aim_gain            <= pwdata[15:0];
        rlasp_pkg::REG_SPEED: cfg_q.speed_limit         <= pwdata[30:0];
        rlasp_pkg::REG_VSTEP: cfg_q.velocity_step_limit <= pwdata[30:0];
        rlasp_pkg::REG_TICK:  cfg_q.tick_period         <= pwdata[15:0];
        rlasp_pkg::REG_LOWER: cfg_q.lower_angle_limit   <= pwdata;
        rlasp_pkg::REG_UPPER: cfg_q.upper_angle_limit   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      rlasp_pkg::REG_GAIN:  prdata = {16'd0, cfg_q.aim_gain};
      rlasp_pkg::REG_SPEED: prdata = {1'b0, cfg_q.speed_limit};
      rlasp_pkg::REG_VSTEP: prdata = {1'b0, cfg_q.velocity_step_limit};
      rlasp_pkg::REG_TICK:  prdata = {16'd0, cfg_q.tick_period};
      rlasp_pkg::REG_LOWER: prdata = cfg_q.lower_angle_limit;
      rlasp_pkg::REG_UPPER: prdata = cfg_q.upper_angle_limit;
      default:              prdata = '0;
    endcase
  end

endmodule

### design/rlasp_ctrl.sv
module rlasp_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rlasp_pkg::cmd_t cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GOAL,
    ST_ERR,
    ST_MULG,
    ST_VCMD,
    ST_VEL,
    ST_MULT,
    ST_UPD
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_valid_d = cmd_o.upd_en || (out_valid_q && !out_ready_i);

  always_comb begin
    cmd_o         = '0;
    cmd_o.load    = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.goal_en = (state_q == ST_GOAL);
    cmd_o.err_en  = (state_q == ST_ERR);
    cmd_o.mulg_en = (state_q == ST_MULG);
    cmd_o.vcmd_en = (state_q == ST_VCMD);
    cmd_o.vel_en  = (state_q == ST_VEL);
    cmd_o.mult_en = (state_q == ST_MULT);
    cmd_o.upd_en  = (state_q == ST_UPD) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_GOAL;
          end
        end
        ST_GOAL: state_q <= ST_ERR;
        ST_ERR:  state_q <= ST_MULG;
        ST_MULG: state_q <= ST_VCMD;
        ST_VCMD: state_q <= ST_VEL;
        ST_VEL:  state_q <= ST_MULT;
        ST_MULT: state_q <= ST_UPD;
        ST_UPD: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### design/rlasp_dp.sv
module rlasp_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rlasp_pkg::cmd_t    cmd_i,
  input  rlasp_pkg::cfg_t    cfg_i,
  input  logic signed [31:0] measured_angle_i,
  input  logic signed [31:0] aim_error_i,
  input  logic signed [31:0] manual_delta_i,
  input  logic               aim_active_i,
  output logic signed [31:0] angle_setpoint_o,
  output logic signed [31:0] planned_velocity_o,
  output logic               goal_reached_o
);

  logic signed [31:0] meas_q, aerr_q, delta_q;
  logic               active_q;
  logic signed [31:0] goal_q;
  logic signed [32:0] err_q;
  logic signed [49:0] prod_q;
  logic signed [31:0] vcmd_q;
  logic signed [31:0] vel_new_q;
  logic signed [31:0] sp_q, vel_q;
  logic signed [31:0] out_sp_q, out_vel_q;
  logic               out_reached_q;

  logic signed [33:0] goal_sum;
  logic signed [49:0] prod_d;
  logic signed [49:0] rnd_g_sum;
  logic signed [41:0] rnd_g;
  logic signed [41:0] speed_x;
  logic signed [31:0] vcmd_d;
  logic signed [32:0] dv_diff;
  logic signed [32:0] vstep_x;
  logic signed [31:0] dv;
  logic signed [49:0] rnd_t_sum;
  logic signed [33:0] step;
  logic signed [33:0] err_x;
  logic               snap;
  logic signed [33:0] step_f;
  logic signed [31:0] sp_pre;
  logic signed [31:0] sp_d, vel_d;
  logic               reached_d;

  assign goal_sum = {{2{meas_q[31]}}, meas_q} + {{2{aerr_q[31]}}, aerr_q}
                  + {{2{delta_q[31]}}, delta_q};

  always_comb begin
    if (cmd_i.mulg_en) begin
      prod_d = 50'($signed({1'b0, cfg_i.aim_gain}) * err_q);
    end else begin
      prod_d = 50'(vel_new_q * $signed({1'b0, cfg_i.tick_period}));
    end
  end

  assign rnd_g_sum = prod_q + 50'sd128;
  assign rnd_g     = rnd_g_sum[49:8];
  assign speed_x   = {11'd0, cfg_i.speed_limit};

  always_comb begin
    if (rnd_g > speed_x) begin
      vcmd_d = {1'b0, cfg_i.speed_limit};
    end else if (rnd_g < -speed_x) begin
      vcmd_d = -$signed({1'b0, cfg_i.speed_limit});
    end else begin
      vcmd_d = rnd_g[31:0];
    end
  end

  assign dv_diff = {vcmd_q[31], vcmd_q} - {vel_q[31], vel_q};
  assign vstep_x = {2'd0, cfg_i.velocity_step_limit};

  always_comb begin
    if (dv_diff > vstep_x) begin
      dv = {1'b0, cfg_i.velocity_step_limit};
    end else if (dv_diff < -vstep_x) begin
      dv = -$signed({1'b0, cfg_i.velocity_step_limit});
    end else begin
      dv = dv_diff[31:0];
    end
  end

  assign rnd_t_sum = prod_q + 50'sd32768;
  assign step      = rnd_t_sum[49:16];
  assign err_x     = {err_q[32], err_q};
  assign snap      = ((err_x > 34'sd0) && (step > err_x))
                  || ((err_x < 34'sd0) && (step < err_x));
  assign step_f    = snap ? err_x : step;

  always_comb begin
    reached_d = 1'b0;
    if (active_q) begin
      if (cfg_i.tick_period != '0) begin
        sp_pre    = rlasp_pkg::sat34({{2{sp_q[31]}}, sp_q} + step_f);
        vel_d     = snap ? 32'sd0 : vel_new_q;
        reached_d = snap;
      end else begin
        sp_pre = sp_q;
        vel_d  = vel_q;
      end
    end else begin
      sp_pre = rlasp_pkg::sat34({{2{sp_q[31]}}, sp_q} + {{2{delta_q[31]}}, delta_q});
      vel_d  = 32'sd0;
    end
    sp_d = rlasp_pkg::clamp32(sp_pre, cfg_i.lower_angle_limit, cfg_i.upper_angle_limit);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      meas_q   <= measured_angle_i;
      aerr_q   <= aim_error_i;
      delta_q  <= manual_delta_i;
      active_q <= aim_active_i;
    end
    if (cmd_i.goal_en) begin
      goal_q <= rlasp_pkg::clamp32(rlasp_pkg::sat34(goal_sum),
                                   cfg_i.lower_angle_limit, cfg_i.upper_angle_limit);
    end
    if (cmd_i.err_en) begin
      err_q <= {goal_q[31], goal_q} - {sp_q[31], sp_q};
    end
    if (cmd_i.mulg_en || cmd_i.mult_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.vcmd_en) begin
      vcmd_q <= vcmd_d;
    end
    if (cmd_i.vel_en) begin
      vel_new_q <= rlasp_pkg::sat34({{2{vel_q[31]}}, vel_q} + {{2{dv[31]}}, dv});
    end
    if (cmd_i.upd_en) begin
      out_sp_q      <= sp_d;
      out_vel_q     <= vel_d;
      out_reached_q <= reached_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q  <= '0;
      vel_q <= '0;
    end else if (cmd_i.upd_en) begin
      sp_q  <= sp_d;
      vel_q <= vel_d;
    end
  end

  assign angle_setpoint_o   = out_sp_q;
  assign planned_velocity_o = out_vel_q;
  assign goal_reached_o     = out_reached_q;

endmodule
